### hdl/two_stack_queue_core_defines.svh
// Assertion macros shared by the queue RTL.
`ifndef TWO_STACK_QUEUE_CORE_DEFINES_SVH
`define TWO_STACK_QUEUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define TSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define TSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hdl/tsq_pkg.sv
package tsq_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int VALUE_W         = 32;
    localparam int STATUS_W        = 3;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic                t_op;

    localparam t_op OP_ENQ = 1'b0;
    localparam t_op OP_DEQ = 1'b1;

    localparam t_status ST_STORED      = 3'd0;
    localparam t_status ST_STORED_FULL = 3'd1;
    localparam t_status ST_DROPPED     = 3'd2;
    localparam t_status ST_DEQUEUED    = 3'd3;
    localparam t_status ST_EMPTY       = 3'd4;

endpackage

### hdl/tsq_ram.sv
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/two_stack_queue_core.sv
// Two-stack FIFO queue core.
// Command channel: an item (i_op, i_in_value) is taken at a rising edge with
// start high and busy low. i_op selects enqueue or dequeue.
// Result channel: each item yields exactly one result on o_out_value and
// o_status, valid for the single cycle in which o_strobe is high. The
// receiver cannot stall; a result must be taken in that cycle.
// A plain enqueue reports its result in the cycle after acceptance and leaves
// busy low, so enqueues run at one per cycle. A dequeue from a non-empty
// back stack goes through the read register of the back stack memory and
// then through the output register.
// Refill: when the front stack must be moved to the back stack, the block
// streams one entry per cycle from the front memory to the back memory
// before the result; this transfer sets the worst-case time for one item.
// Reset (synchronous, active low) empties both stacks at once; memory
// contents are left as they are and need no clearing pass.
// Capacity is 2 * STACK_DEPTH values.
`include "two_stack_queue_core_defines.svh"

module two_stack_queue_core #(
    parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  tsq_pkg::t_op                          i_op,
    input  logic signed [tsq_pkg::VALUE_W-1:0]    i_in_value,
    output logic                                  o_strobe,
    output logic signed [tsq_pkg::VALUE_W-1:0]    o_out_value,
    output tsq_pkg::t_status                      o_status
);

    import tsq_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] FULL     = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] NEARFULL = CW'(STACK_DEPTH - 1);
    localparam logic [CW-1:0] ZERO     = '0;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOVE = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_fc, n_fc;
    logic [CW-1:0]      r_bc, n_bc;
    logic               r_mv_vld, n_mv_vld;
    logic               r_push_pend, n_push_pend;
    t_op                r_op, n_op;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_strobe, n_strobe;
    logic [VALUE_W-1:0] r_out, n_out;
    t_status            r_status, n_status;

    logic               front_we, front_re, back_we, back_re;
    logic [AW-1:0]      front_waddr, front_raddr, back_waddr, back_raddr;
    logic [VALUE_W-1:0] front_wdata, front_rdata, back_rdata;
    logic [CW-1:0]      fc_dec, bc_dec;
    logic [CW:0]        w_total;

    assign fc_dec  = r_fc - 1'b1;
    assign bc_dec  = r_bc - 1'b1;
    assign w_total = {1'b0, r_fc} + {1'b0, r_bc} + {{CW{1'b0}}, r_mv_vld};

    tsq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_front_ram (
        .i_clk     (i_clk),
        .i_wr_en   (front_we),
        .i_wr_addr (front_waddr),
        .i_wr_data (front_wdata),
        .i_rd_en   (front_re),
        .i_rd_addr (front_raddr),
        .o_rd_data (front_rdata)
    );

    tsq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_back_ram (
        .i_clk     (i_clk),
        .i_wr_en   (back_we),
        .i_wr_addr (back_waddr),
        .i_wr_data (front_rdata),
        .i_rd_en   (back_re),
        .i_rd_addr (back_raddr),
        .o_rd_data (back_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_fc        = r_fc;
        n_bc        = r_bc;
        n_mv_vld    = r_mv_vld;
        n_push_pend = r_push_pend;
        n_op        = r_op;
        n_value     = r_value;
        n_strobe    = 1'b0;
        n_out       = '0;
        n_status    = ST_STORED;
        front_we    = 1'b0;
        front_waddr = r_fc[AW-1:0];
        front_wdata = r_value;
        front_re    = 1'b0;
        front_raddr = fc_dec[AW-1:0];
        back_we     = 1'b0;
        back_waddr  = r_bc[AW-1:0];
        back_re     = 1'b0;
        back_raddr  = bc_dec[AW-1:0];

        case (r_state)
            S_IDLE: begin
                n_mv_vld = 1'b0;
                if (start) begin
                    n_op        = i_op;
                    n_value     = i_in_value;
                    n_push_pend = 1'b0;
                    if (i_op == OP_ENQ) begin
                        if (r_fc == FULL) begin
                            if (r_bc == ZERO) begin
                                n_push_pend = 1'b1;
                                n_state     = S_MOVE;
                            end else begin
                                n_strobe = 1'b1;
                                n_status = ST_DROPPED;
                            end
                        end else begin
                            front_we    = 1'b1;
                            front_wdata = i_in_value;
                            n_fc        = r_fc + 1'b1;
                            if (r_fc == NEARFULL && r_bc == ZERO) begin
                                n_state = S_MOVE;
                            end else begin
                                n_strobe = 1'b1;
                                n_status = (r_fc == NEARFULL) ? ST_STORED_FULL : ST_STORED;
                            end
                        end
                    end else begin
                        if (r_bc == ZERO) begin
                            if (r_fc == ZERO) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_MOVE;
                            end
                        end else begin
                            back_re = 1'b1;
                            n_bc    = bc_dec;
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_MOVE: begin
                if (r_mv_vld) begin
                    back_we = 1'b1;
                    n_bc    = r_bc + 1'b1;
                end
                if (r_fc != ZERO) begin
                    front_re = 1'b1;
                    n_fc     = fc_dec;
                    n_mv_vld = 1'b1;
                end else begin
                    n_mv_vld = 1'b0;
                    if (!r_mv_vld) begin
                        if (r_op == OP_ENQ) begin
                            if (r_push_pend) begin
                                front_we = 1'b1;
                                n_fc     = r_fc + 1'b1;
                            end
                            n_push_pend = 1'b0;
                            n_strobe    = 1'b1;
                            n_status    = ST_STORED;
                            n_state     = S_IDLE;
                        end else begin
                            back_re = 1'b1;
                            n_bc    = bc_dec;
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_POP: begin
                n_strobe = 1'b1;
                n_out    = back_rdata;
                n_status = ST_DEQUEUED;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fc        <= '0;
            r_bc        <= '0;
            r_mv_vld    <= 1'b0;
            r_push_pend <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fc        <= n_fc;
            r_bc        <= n_bc;
            r_mv_vld    <= n_mv_vld;
            r_push_pend <= n_push_pend;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_value  <= n_value;
        r_out    <= n_out;
        r_status <= n_status;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_out_value = r_out;
    assign o_status    = r_status;

    `TSQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, (r_fc <= FULL) && (r_bc <= FULL), "stack count beyond depth")
    `TSQ_ASSERT_NXT(a_move_conserve, i_clk, i_rst_n, (r_state == S_MOVE) && (n_state == S_MOVE), w_total == $past(w_total), "entries lost during refill")
    `TSQ_ASSERT_IMP(a_idle_no_xfer, i_clk, i_rst_n, r_state == S_IDLE, !r_mv_vld, "refill transfer pending while idle")
    `TSQ_ASSERT_IMP(a_zero_value, i_clk, i_rst_n, o_strobe && (o_status != ST_DEQUEUED), o_out_value == '0, "value on non-dequeue result")

endmodule

### tb/sv/tb_two_stack_queue_core.sv
`timescale 1ns / 100ps

module tb_two_stack_queue_core;
    import tsq_pkg::*;

    localparam int DEPTH          = STACK_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 8 * (DEPTH + 4) + 100;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_outcome;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    t_op                       i_op;
    logic signed [VALUE_W-1:0] i_in_value;
    logic                      o_strobe;
    logic signed [VALUE_W-1:0] o_out_value;
    t_status                   o_status;

    logic [VALUE_W-1:0] front_mem [DEPTH];
    logic [VALUE_W-1:0] back_mem [DEPTH];
    int                 front_fill;
    int                 back_fill;

    t_outcome outcomes_due[$];
    t_outcome due;
    int       mismatches;
    int       commands_sent;
    int       status_seen [5];
    int       stall_cycles;
    bit       idle_on;

    two_stack_queue_core #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_in_value  (i_in_value),
        .o_strobe    (o_strobe),
        .o_out_value (o_out_value),
        .o_status    (o_status)
    );

    always #1 i_clk = ~i_clk;

    function automatic void spill_front_to_back();
        while (front_fill > 0 && back_fill < DEPTH) begin
            front_fill--;
            back_mem[back_fill] = front_mem[front_fill];
            back_fill++;
        end
    endfunction

    function automatic t_outcome queue_outcome(input t_op op, input logic [VALUE_W-1:0] val);
        t_outcome res;
        res.value = '0;
        if (op == OP_ENQ) begin
            if (front_fill >= DEPTH) begin
                if (back_fill == 0) begin
                    spill_front_to_back();
                    front_mem[front_fill] = val;
                    front_fill++;
                    res.status = ST_STORED;
                end else begin
                    res.status = ST_DROPPED;
                end
            end else begin
                front_mem[front_fill] = val;
                front_fill++;
                if (front_fill >= DEPTH) begin
                    if (back_fill == 0) begin
                        spill_front_to_back();
                        res.status = ST_STORED;
                    end else begin
                        res.status = ST_STORED_FULL;
                    end
                end else begin
                    res.status = ST_STORED;
                end
            end
        end else begin
            if (back_fill == 0)
                spill_front_to_back();
            if (back_fill > 0) begin
                back_fill--;
                res.value  = back_mem[back_fill];
                res.status = ST_DEQUEUED;
            end else begin
                res.status = ST_EMPTY;
            end
        end
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic send_cmd(input t_op op, input logic [VALUE_W-1:0] val);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 21) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= op;
        i_in_value <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        outcomes_due.push_back(queue_outcome(op, val));
        commands_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_and_extremes();
        logic [VALUE_W-1:0] corners [7];
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                    32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001};
        send_cmd(OP_DEQ, 32'h1234_5678);
        foreach (corners[k])
            send_cmd(OP_ENQ, corners[k]);
        repeat (7)
            send_cmd(OP_DEQ, $urandom);
        send_cmd(OP_DEQ, $urandom);
        send_cmd(OP_ENQ, pick_value());
        send_cmd(OP_ENQ, pick_value());
        send_cmd(OP_DEQ, $urandom);
        send_cmd(OP_ENQ, pick_value());
        send_cmd(OP_DEQ, $urandom);
        send_cmd(OP_DEQ, $urandom);
    endtask

    task automatic test_capacity_limits();
        repeat (DEPTH)
            send_cmd(OP_ENQ, pick_value());
        repeat (DEPTH)
            send_cmd(OP_ENQ, pick_value());
        repeat (3)
            send_cmd(OP_ENQ, pick_value());
        repeat (DEPTH)
            send_cmd(OP_DEQ, $urandom);
        send_cmd(OP_ENQ, pick_value());
        repeat (DEPTH + 3)
            send_cmd(OP_DEQ, $urandom);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int burst;
        int enq_pct;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            burst = $urandom_range(10, 80);
            case ($urandom_range(2))
                0:       enq_pct = 80;
                1:       enq_pct = 50;
                default: enq_pct = 20;
            endcase
            idle_on = !(sent >= n_items / 4 && sent < n_items / 2);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                send_cmd(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ, pick_value());
                sent++;
            end
            if (!paused && sent >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        idle_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch("unexpected result", o_out_value, '0);
            end else begin
                due = outcomes_due.pop_front();
                if (o_out_value !== due.value)
                    report_mismatch("out_value", o_out_value, due.value);
                if (o_status !== due.status)
                    report_mismatch("status", 32'(o_status), 32'(due.status));
            end
            if (o_status <= ST_EMPTY)
                status_seen[o_status]++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("tb_two_stack_queue_core NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = OP_ENQ;
        i_in_value    = '0;
        front_fill    = 0;
        back_fill     = 0;
        mismatches    = 0;
        commands_sent = 0;
        stall_cycles  = 0;
        idle_on       = 1'b1;
        foreach (status_seen[k])
            status_seen[k] = 0;

        repeat (4)
            @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_extremes();
        test_capacity_limits();
        test_random_traffic(260);

        wait_drained();
        repeat (DEPTH + 8)
            @(posedge i_clk);

        $display("ran %0d transactions through a %0d-entry queue", commands_sent, 2 * DEPTH);
        $display("stored %0d, stored-full %0d, dropped %0d, dequeued %0d, empty %0d",
                 status_seen[ST_STORED], status_seen[ST_STORED_FULL],
                 status_seen[ST_DROPPED], status_seen[ST_DEQUEUED], status_seen[ST_EMPTY]);
        if (mismatches == 0 && outcomes_due.size() == 0)
            $display("tb_two_stack_queue_core OK");
        else
            $display("tb_two_stack_queue_core NOT OK");
        $finish;
    end

endmodule

### two_stack_queue_core.f
+incdir+hdl
hdl/tsq_pkg.sv
hdl/tsq_ram.sv
hdl/two_stack_queue_core.sv
tb/sv/tb_two_stack_queue_core.sv
